>>> rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16LE to UTF-8 converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int CAPACITY_WIDTH = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int UNIT_WIDTH     = 16;
    localparam int CP_WIDTH       = 21;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'd1024;

    // queue between the classifier and the byte sequencer
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // result status codes
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // code unit ranges
    localparam logic [UNIT_WIDTH-1:0] UNIT_NUL     = 16'h0000;
    localparam logic [UNIT_WIDTH-1:0] UNIT_NONCHAR = 16'hFFFF;
    localparam logic [UNIT_WIDTH-1:0] HIGH_FIRST   = 16'hD800;
    localparam logic [UNIT_WIDTH-1:0] HIGH_LAST    = 16'hDBFF;
    localparam logic [UNIT_WIDTH-1:0] LOW_FIRST    = 16'hDC00;
    localparam logic [UNIT_WIDTH-1:0] LOW_LAST     = 16'hDFFF;

    localparam logic [CP_WIDTH-1:0] CP_SUPP_BASE = 21'h10000;
    localparam logic [CP_WIDTH-1:0] CP_MAX_1B    = 21'h0007F;
    localparam logic [CP_WIDTH-1:0] CP_MAX_2B    = 21'h007FF;
    localparam logic [CP_WIDTH-1:0] CP_MAX_3B    = 21'h0FFFF;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;
    localparam logic [7:0] CONT_M  = 8'h3F;

    // one queued byte run: data bytes, then an optional closing result
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
        logic            has_tail;
        logic [1:0]      tail_status;
    } t_run;

    // clamp the configured capacity to the range of the space counter
    function automatic logic [CAPACITY_WIDTH-1:0] sat_cap(input logic [CFG_WIDTH-1:0] v);
        logic [32:0] ext;
        logic [32:0] lim;
        ext = 33'(v);
        lim = (33'(1) << CAPACITY_WIDTH) - 33'(1);
        if (ext > lim) begin
            sat_cap = CAPACITY_WIDTH'(lim);
        end else begin
            sat_cap = CAPACITY_WIDTH'(ext);
        end
    endfunction

endpackage

>>> rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, tracks capacity and builds byte runs.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [u16u8_pkg::UNIT_WIDTH-1:0]  i_code_unit,
    input  logic                              i_last_unit,
    input  logic                              i_cfg_valid,
    input  logic [u16u8_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    input  logic                              i_full,
    output logic                              o_push,
    output u16u8_pkg::t_run                   o_run
);

    localparam int CW = u16u8_pkg::CAPACITY_WIDTH;

    logic [u16u8_pkg::CFG_WIDTH-1:0] r_capacity;
    logic                            r_name_start, n_name_start;
    logic                            r_high_pending, n_high_pending;
    logic [9:0]                      r_high_bits, n_high_bits;
    logic [CW-1:0]                   r_space_left, n_space_left;
    logic                            r_skip_rest, n_skip_rest;

    logic                               accept;
    logic [CW-1:0]                      cap_sat;
    logic [CW-1:0]                      cs_space;
    logic                               cs_hp;
    logic                               cs_skip;
    logic                               is_high;
    logic                               is_low;
    logic                               is_end;
    logic [u16u8_pkg::CP_WIDTH-1:0]     cp;
    logic [2:0]                         need;
    logic                               do_run;
    logic                               has_result;
    u16u8_pkg::t_run                    run;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !i_full;
    assign cap_sat    = u16u8_pkg::sat_cap(r_capacity);
    assign cs_space   = r_name_start ? cap_sat : r_space_left;
    assign cs_hp      = r_name_start ? 1'b0 : r_high_pending;
    assign cs_skip    = r_name_start ? 1'b0 : r_skip_rest;

    assign is_high = (i_code_unit >= u16u8_pkg::HIGH_FIRST) &&
                     (i_code_unit <= u16u8_pkg::HIGH_LAST);
    assign is_low  = (i_code_unit >= u16u8_pkg::LOW_FIRST) &&
                     (i_code_unit <= u16u8_pkg::LOW_LAST);
    assign is_end  = (i_code_unit == u16u8_pkg::UNIT_NUL) ||
                     (i_code_unit == u16u8_pkg::UNIT_NONCHAR);

    always_comb begin
        if (cs_hp) begin
            cp = u16u8_pkg::CP_SUPP_BASE + {1'b0, r_high_bits, i_code_unit[9:0]};
        end else begin
            cp = u16u8_pkg::CP_WIDTH'(i_code_unit);
        end
        if (cp <= u16u8_pkg::CP_MAX_1B) begin
            need = 3'd1;
        end else if (cp <= u16u8_pkg::CP_MAX_2B) begin
            need = 3'd2;
        end else if (cp <= u16u8_pkg::CP_MAX_3B) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
    end

    always_comb begin
        n_name_start   = 1'b0;
        n_high_pending = cs_hp;
        n_high_bits    = r_high_bits;
        n_space_left   = cs_space;
        n_skip_rest    = cs_skip;
        do_run         = 1'b0;
        has_result     = 1'b0;
        run.bytes       = '0;
        run.len         = 3'd0;
        run.has_tail    = 1'b0;
        run.tail_status = u16u8_pkg::ST_DATA;

        if (r_name_start && (cap_sat == '0)) begin
            has_result = 1'b1;
        end else if (cs_skip) begin
            if (i_last_unit) begin
                n_name_start = 1'b1;
                n_skip_rest  = 1'b0;
            end
        end else if (cs_hp) begin
            n_high_pending = 1'b0;
            has_result     = 1'b1;
            do_run         = is_low;
        end else if (is_end) begin
            has_result = 1'b1;
            if (cs_space != '0) begin
                run.has_tail    = 1'b1;
                run.tail_status = u16u8_pkg::ST_DONE;
                if (i_last_unit) begin
                    n_name_start = 1'b1;
                    n_skip_rest  = 1'b0;
                end else begin
                    n_skip_rest = 1'b1;
                end
            end
        end else if (is_high) begin
            if (i_last_unit) begin
                has_result = 1'b1;
            end else begin
                n_high_pending = 1'b1;
                n_high_bits    = i_code_unit[9:0];
            end
        end else begin
            has_result = 1'b1;
            do_run     = !is_low;
        end

        // a run must leave one byte free
        if (do_run && (cs_space < (CW'(need) + CW'(1)))) begin
            do_run = 1'b0;
        end

        if (do_run) begin
            run.len = need;
            unique case (need)
                3'd1: begin
                    run.bytes[0] = cp[7:0];
                end
                3'd2: begin
                    run.bytes[0] = u16u8_pkg::LEAD_2B | {3'b000, cp[10:6]};
                    run.bytes[1] = u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M);
                end
                3'd3: begin
                    run.bytes[0] = u16u8_pkg::LEAD_3B | {4'b0000, cp[15:12]};
                    run.bytes[1] = u16u8_pkg::CONT_B | {2'b00, cp[11:6]};
                    run.bytes[2] = u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M);
                end
                default: begin
                    run.bytes[0] = u16u8_pkg::LEAD_4B | {5'b00000, cp[20:18]};
                    run.bytes[1] = u16u8_pkg::CONT_B | {2'b00, cp[17:12]};
                    run.bytes[2] = u16u8_pkg::CONT_B | {2'b00, cp[11:6]};
                    run.bytes[3] = u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M);
                end
            endcase
            n_space_left = cs_space - CW'(need);
            if (i_last_unit) begin
                run.has_tail    = 1'b1;
                run.tail_status = u16u8_pkg::ST_DONE;
                n_name_start    = 1'b1;
            end
        end else if (has_result && !run.has_tail) begin
            // error: drop the rest of the name
            run.has_tail    = 1'b1;
            run.tail_status = u16u8_pkg::ST_ERROR;
            n_skip_rest     = 1'b1;
            n_high_pending  = 1'b0;
            n_name_start    = i_last_unit;
        end
    end

    assign o_push = accept && has_result;
    assign o_run  = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= u16u8_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_start   <= 1'b1;
            r_high_pending <= 1'b0;
            r_high_bits    <= '0;
            r_space_left   <= '0;
            r_skip_rest    <= 1'b0;
        end else if (accept) begin
            r_name_start   <= n_name_start;
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
            r_space_left   <= n_space_left;
            r_skip_rest    <= n_skip_rest;
        end
    end

endmodule

>>> rtl/u16u8_fifo.sv
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of byte runs between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module u16u8_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u16u8_pkg::t_run i_wr_data,
    input  logic            i_pop,
    output u16u8_pkg::t_run o_rd_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = u16u8_pkg::FIFO_AW;
    localparam int CW = u16u8_pkg::FIFO_CW;

    u16u8_pkg::t_run r_mem [u16u8_pkg::FIFO_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full    = (r_count == CW'(u16u8_pkg::FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(u16u8_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(u16u8_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Byte sequencer: plays queued runs out one result per cycle when not stalled.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  u16u8_pkg::t_run i_run,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_status,
    output logic            o_run_last
);

    u16u8_pkg::t_run r_cur;
    logic            r_busy;
    logic [2:0]      r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic [1:0]      r_status;
    logic            r_run_last;

    logic       free;
    logic       emit;
    logic       load;
    logic [2:0] total;
    logic       cur_last;
    logic [7:0] cur_byte;
    logic [1:0] cur_status;

    assign free     = !r_out_valid || i_out_ready;
    assign emit     = free && r_busy;
    assign total    = r_cur.len + {2'b00, r_cur.has_tail};
    assign cur_last = (r_idx == (total - 3'd1));
    assign load     = !i_empty && (!r_busy || (emit && cur_last));
    assign o_pop    = load;

    always_comb begin
        if (r_idx < r_cur.len) begin
            cur_byte   = r_cur.bytes[r_idx[1:0]];
            cur_status = u16u8_pkg::ST_DATA;
        end else begin
            cur_byte   = '0;
            cur_status = r_cur.tail_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_run;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_status   <= cur_status;
            r_run_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (free) begin
                r_out_valid <= r_busy;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
                if (cur_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_status;
    assign o_run_last  = r_run_last;

endmodule

>>> rtl/utf16le_to_utf8_converter.sv
// ----------------------------------------------------------------------------
// utf16le_to_utf8_converter
// Converts UTF-16LE file name code units into UTF-8 bytes with a terminator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one 16-bit code unit per transaction with a last-unit flag.
//   Output channel: one result per transaction (byte, status, run_last).
//   Config channel: write the output capacity in bytes, terminator included;
//     it is sampled at the first unit of each name. o_cfg_ready is always high.
//   Each accepted unit gives 0 to 5 results; the final one carries run_last.
//   Results pass through the run queue, run register and output register.
//   Throughput: one result per cycle on the output when it is not stalled;
//     the byte sequencer and its single output port set this rate.
//   A two-entry run queue lets the input keep taking units while results wait.
//   Reset: capacity returns to 1024, the next unit starts a new name, and the
//     queue and output register are emptied.
//   When the receiver stalls, the output holds; once the queue fills,
//     o_in_ready falls until room frees up.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [u16u8_pkg::UNIT_WIDTH-1:0] i_code_unit,
    input  logic                             i_last_unit,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic [1:0]                       o_status,
    output logic                             o_run_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [u16u8_pkg::CFG_WIDTH-1:0]  i_cfg_data
);

    u16u8_pkg::t_run wr_run;
    u16u8_pkg::t_run rd_run;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    assign o_cfg_ready = 1'b1;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_run       (wr_run)
    );

    u16u8_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_run),
        .i_pop     (pop),
        .o_rd_data (rd_run),
        .o_full    (full),
        .o_empty   (empty)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_run       (rd_run),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

endmodule

>>> rtl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks of the converter's output channel.
// ----------------------------------------------------------------------------
module u16u8_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [u16u8_pkg::UNIT_WIDTH-1:0] i_code_unit,
    input logic                             i_last_unit,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [7:0]                       o_out_byte,
    input logic [1:0]                       o_status,
    input logic                             o_run_last,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [u16u8_pkg::CFG_WIDTH-1:0]  i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_status) && $stable(o_run_last))
        else $error("output changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == u16u8_pkg::ST_DATA) ||
        (o_status == u16u8_pkg::ST_DONE) || (o_status == u16u8_pkg::ST_ERROR))
        else $error("undefined status code");

    // terminator and error close their run and carry a zero byte
    a_tail_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != u16u8_pkg::ST_DATA) |-> o_run_last && (o_out_byte == 8'h00))
        else $error("terminator or error not last or not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind utf16le_to_utf8_converter u16u8_checker u_chk (.*);

>>> tb/sv/utf8_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches the code unit, result and capacity channels of the converter. For
// every accepted code unit it predicts the UTF-8 results and checks each
// result transaction against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [u16u8_pkg::UNIT_WIDTH-1:0] i_code_unit,
    input  logic                             i_last_unit,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [7:0]                       i_out_byte,
    input  logic [1:0]                       i_status,
    input  logic                             i_run_last,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [u16u8_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding,
    output int                               o_results_seen,
    output int                               o_terminators,
    output int                               o_errors
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       run_last;
    } t_utf8_result;

    t_utf8_result utf8_expected [$];

    // predictor state
    logic [u16u8_pkg::CFG_WIDTH-1:0]      capacity_reg;
    logic                                 name_start;
    logic                                 high_pending;
    logic [9:0]                           high_bits;
    logic [u16u8_pkg::CAPACITY_WIDTH-1:0] space_left;
    logic                                 skip_rest;

    int           mismatches;
    int           results_seen;
    int           terminators;
    int           errors;
    t_utf8_result want;

    task automatic flag_error(input logic last);
        skip_rest    = 1'b1;
        high_pending = 1'b0;
        if (last) begin
            name_start = 1'b1;
        end
        utf8_expected.push_back('{data: 8'h00, status: u16u8_pkg::ST_ERROR, run_last: 1'b1});
    endtask

    task automatic transcode_unit(input logic [u16u8_pkg::UNIT_WIDTH-1:0] unit,
                                  input logic last);
        t_utf8_result                         run [$];
        logic [u16u8_pkg::CP_WIDTH-1:0]       cp;
        logic [63:0]                          cap_limit;
        logic [u16u8_pkg::CAPACITY_WIDTH-1:0] start_space;
        int                                   need;

        if (name_start) begin
            // sample and clamp the capacity at the first unit of a name
            cap_limit = (u16u8_pkg::CAPACITY_WIDTH >= 32) ? 64'hFFFF_FFFF
                        : (64'd1 << u16u8_pkg::CAPACITY_WIDTH) - 64'd1;
            start_space = (64'(capacity_reg) > cap_limit)
                          ? u16u8_pkg::CAPACITY_WIDTH'(cap_limit)
                          : u16u8_pkg::CAPACITY_WIDTH'(capacity_reg);
            space_left   = start_space;
            name_start   = 1'b0;
            high_pending = 1'b0;
            skip_rest    = 1'b0;
            if (start_space == '0) begin
                flag_error(last);
                return;
            end
        end

        if (skip_rest) begin
            if (last) begin
                name_start = 1'b1;
                skip_rest  = 1'b0;
            end
            return;
        end

        if (high_pending) begin
            high_pending = 1'b0;
            if (unit < u16u8_pkg::LOW_FIRST || unit > u16u8_pkg::LOW_LAST) begin
                flag_error(last);
                return;
            end
            cp = u16u8_pkg::CP_SUPP_BASE + u16u8_pkg::CP_WIDTH'({high_bits, unit[9:0]});
        end else if (unit == u16u8_pkg::UNIT_NUL || unit == u16u8_pkg::UNIT_NONCHAR) begin
            if (space_left == '0) begin
                flag_error(last);
                return;
            end
            utf8_expected.push_back('{data: 8'h00, status: u16u8_pkg::ST_DONE,
                                      run_last: 1'b1});
            skip_rest = 1'b1;
            if (last) begin
                name_start = 1'b1;
                skip_rest  = 1'b0;
            end
            return;
        end else if (unit >= u16u8_pkg::HIGH_FIRST && unit <= u16u8_pkg::HIGH_LAST) begin
            if (last) begin
                flag_error(last);
                return;
            end
            // hold the high half until its partner arrives
            high_pending = 1'b1;
            high_bits    = unit[9:0];
            return;
        end else if (unit >= u16u8_pkg::LOW_FIRST && unit <= u16u8_pkg::LOW_LAST) begin
            flag_error(last);
            return;
        end else begin
            cp = u16u8_pkg::CP_WIDTH'(unit);
        end

        need = (cp <= u16u8_pkg::CP_MAX_1B) ? 1 : (cp <= u16u8_pkg::CP_MAX_2B) ? 2 :
               (cp <= u16u8_pkg::CP_MAX_3B) ? 3 : 4;
        // keep one byte free for the terminator
        if (int'(space_left) < need + 1) begin
            flag_error(last);
            return;
        end

        case (need)
            1: begin
                run.push_back('{data: cp[7:0], status: u16u8_pkg::ST_DATA, run_last: 1'b0});
            end
            2: begin
                run.push_back('{data: u16u8_pkg::LEAD_2B | 8'(cp >> 6),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
            end
            3: begin
                run.push_back('{data: u16u8_pkg::LEAD_3B | 8'(cp >> 12),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (8'(cp >> 6) & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
            end
            default: begin
                run.push_back('{data: u16u8_pkg::LEAD_4B | 8'(cp >> 18),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (8'(cp >> 12) & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (8'(cp >> 6) & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
                run.push_back('{data: u16u8_pkg::CONT_B | (cp[7:0] & u16u8_pkg::CONT_M),
                                status: u16u8_pkg::ST_DATA, run_last: 1'b0});
            end
        endcase
        space_left = space_left - u16u8_pkg::CAPACITY_WIDTH'(need);

        if (last) begin
            run.push_back('{data: 8'h00, status: u16u8_pkg::ST_DONE, run_last: 1'b0});
            name_start = 1'b1;
        end
        run[run.size() - 1].run_last = 1'b1;
        foreach (run[i]) begin
            utf8_expected.push_back(run[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_reg = u16u8_pkg::CFG_RESET;
            name_start   = 1'b1;
            high_pending = 1'b0;
            high_bits    = '0;
            space_left   = '0;
            skip_rest    = 1'b0;
            utf8_expected.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                transcode_unit(i_code_unit, i_last_unit);
            end
            // a capacity transaction only matters from the next unit on
            if (i_cfg_valid && i_cfg_ready) begin
                capacity_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (i_status == u16u8_pkg::ST_DONE) begin
                    terminators++;
                end
                if (i_status == u16u8_pkg::ST_ERROR) begin
                    errors++;
                end
                if (utf8_expected.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %02h %0d %0b",
                             $time, "got byte, status, run_last", i_out_byte, i_status,
                             i_run_last);
                    mismatches++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (want.data !== i_out_byte) begin
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, i_out_byte);
                        mismatches++;
                    end
                    if (want.status !== i_status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_status);
                        mismatches++;
                    end
                    if (want.run_last !== i_run_last) begin
                        $display("%0t: run_last mismatch: expected %0b, got %0b",
                                 $time, want.run_last, i_run_last);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches   <= mismatches;
        o_outstanding  <= utf8_expected.size();
        o_results_seen <= results_seen;
        o_terminators  <= terminators;
        o_errors       <= errors;
    end

endmodule

>>> tb/sv/tb_utf16le_to_utf8_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16le_to_utf8_converter
// Drives file names of UTF-16LE code units into the converter under several
// output capacities and idle mixes, with a long receiver hold-off, and lets a
// side checker compare the UTF-8 results against its own prediction.
// ----------------------------------------------------------------------------
module tb_utf16le_to_utf8_converter;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic [u16u8_pkg::UNIT_WIDTH-1:0] code_unit = '0;
    logic                             last_unit = 1'b0;
    logic                             out_ready = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [u16u8_pkg::CFG_WIDTH-1:0]  cfg_data  = '0;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       cfg_ready;

    int mismatches;
    int outstanding;
    int results_seen;
    int terminators;
    int errors;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int units_sent     = 0;
    int cap_settings   = 1;

    logic [u16u8_pkg::UNIT_WIDTH-1:0] name_units [$];

    utf16le_to_utf8_converter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_code_unit (code_unit),
        .i_last_unit (last_unit),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_status    (status),
        .o_run_last  (run_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    utf8_stream_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_code_unit    (code_unit),
        .i_last_unit    (last_unit),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_byte     (out_byte),
        .i_status       (status),
        .i_run_last     (run_last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_results_seen (results_seen),
        .o_terminators  (terminators),
        .o_errors       (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, outstanding);
        $display("utf16le_to_utf8_converter verification failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_served = 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_unit(input logic [u16u8_pkg::UNIT_WIDTH-1:0] unit, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        code_unit <= unit;
        last_unit <= last;
        do @(posedge clk); while (!in_ready);
        units_sent++;
    endtask

    task automatic send_name();
        foreach (name_units[i]) begin
            send_unit(name_units[i], i == name_units.size() - 1);
        end
    endtask

    // hold the input until every predicted result is back, then pad for latency
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [u16u8_pkg::CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_settings++;
    endtask

    task automatic build_random_name();
        int                               len;
        bit                               noisy;
        logic [u16u8_pkg::UNIT_WIDTH-1:0] u;

        name_units.delete();
        len   = $urandom_range(1, 8);
        noisy = ($urandom_range(99) < 15);
        while (name_units.size() < len) begin
            if (noisy && $urandom_range(99) < 40) begin
                case ($urandom_range(5))
                    1: begin
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(u16u8_pkg::HIGH_FIRST,
                                                                  u16u8_pkg::HIGH_LAST));
                    end
                    2: begin
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(u16u8_pkg::LOW_FIRST,
                                                                  u16u8_pkg::LOW_LAST));
                    end
                    3:       u = u16u8_pkg::UNIT_NUL;
                    4:       u = u16u8_pkg::UNIT_NONCHAR;
                    default: u = u16u8_pkg::UNIT_WIDTH'($urandom);
                endcase
                name_units.push_back(u);
            end else begin
                case ($urandom_range(9)) inside
                    0, 1, 2: begin
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(16'h0001, 16'h007F));
                        name_units.push_back(u);
                    end
                    3, 4: begin
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(16'h0080, 16'h07FF));
                        name_units.push_back(u);
                    end
                    5, 6: begin
                        if ($urandom_range(1)) begin
                            u = u16u8_pkg::UNIT_WIDTH'($urandom_range(16'h0800, 16'hD7FF));
                        end else begin
                            u = u16u8_pkg::UNIT_WIDTH'($urandom_range(16'hE000, 16'hFFFE));
                        end
                        name_units.push_back(u);
                    end
                    default: begin
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(u16u8_pkg::HIGH_FIRST,
                                                                  u16u8_pkg::HIGH_LAST));
                        name_units.push_back(u);
                        u = u16u8_pkg::UNIT_WIDTH'($urandom_range(u16u8_pkg::LOW_FIRST,
                                                                  u16u8_pkg::LOW_LAST));
                        name_units.push_back(u);
                    end
                endcase
            end
        end
        // now and then end a clean name early
        if (!noisy && $urandom_range(99) < 6) begin
            name_units[$urandom_range(name_units.size() - 1)] =
                $urandom_range(1) ? u16u8_pkg::UNIT_NUL : u16u8_pkg::UNIT_NONCHAR;
        end
    endtask

    task automatic run_random_phase(input int target, input int idle_pct, input int stall_pct);
        int first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = units_sent;
        while (units_sent - first < target) begin
            build_random_name();
            send_name();
        end
        drain_results();
    endtask

    initial begin
        int wait_cycles;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names at the reset capacity
        name_units = '{16'h0041};
        send_name();
        name_units = '{16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFE};
        send_name();
        name_units = '{16'hDBFF, 16'hDFFF};
        send_name();
        name_units = '{16'hD800, 16'hDC00};
        send_name();
        name_units = '{16'h0041, 16'h0000, 16'h0042};
        send_name();
        name_units = '{16'hFFFF};
        send_name();
        name_units = '{16'hD800, 16'h0041};
        send_name();
        name_units = '{16'hD900, 16'h0000};
        send_name();
        name_units = '{16'hDBFF};
        send_name();
        name_units = '{16'hDC00};
        send_name();

        // change capacity in the middle of a name: the open name keeps its space
        send_unit(16'h0041, 1'b0);
        drain_results();
        write_capacity(16'd2);
        send_unit(16'h0042, 1'b1);
        name_units = '{16'h00E9};
        send_name();
        drain_results();

        write_capacity(16'd0);
        name_units = '{16'h0041, 16'h0042};
        send_name();
        drain_results();

        // three bytes fit, the next one finds only the terminator's byte left
        write_capacity(16'd4);
        name_units = '{16'h4E2D, 16'h0041};
        send_name();
        drain_results();

        write_capacity(16'd1024);
        run_random_phase(55, 0, 0);
        write_capacity(16'hFFFF);
        run_random_phase(55, 79, 0);
        write_capacity(16'd12);
        run_random_phase(55, 0, 79);
        write_capacity(u16u8_pkg::CFG_WIDTH'($urandom));
        run_random_phase(55, 35, 35);
        write_capacity(16'd6);
        run_random_phase(55, 35, 35);
        write_capacity(u16u8_pkg::CFG_WIDTH'($urandom_range(5, 64)));
        run_random_phase(55, 0, 0);

        // long receiver hold-off while the sender keeps offering units
        write_capacity(16'hFFFF);
        hold_req = 1'b1;
        run_random_phase(40, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        for (wait_cycles = 0; wait_cycles < 20000 && outstanding != 0; wait_cycles++) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (outstanding != 0) begin
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        end
        $display("Sent %0d code units under %0d capacity settings and four idle mixes.",
                 units_sent, cap_settings);
        $display("Checked %0d results: %0d names closed by a terminator, %0d by an error.",
                 results_seen, terminators, errors);
        if (mismatches == 0 && outstanding == 0) begin
            $display("utf16le_to_utf8_converter verification clean");
        end else begin
            $display("utf16le_to_utf8_converter verification failed");
        end
        $finish;
    end

endmodule
